// ===== hw/rtl/frp_pkg.sv =====
// Shared types, codes and helper functions of the FASTA record parser.
`default_nettype none
package frp_pkg;

    localparam int unsigned MAX_NAME    = 64;
    localparam int unsigned NAME_CNT_W  = 7;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_HEADER = 8'h3E;  // '>'
    localparam logic [7:0] CH_BAR    = 8'h7C;  // '|'
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic IN_DATA = 1'b0;
    localparam logic IN_EOS  = 1'b1;

    typedef enum logic [1:0] {
        OK_NAME_BYTE = 2'd0,
        OK_NAME_DONE = 2'd1,
        OK_BASE      = 2'd2,
        OK_REC_DONE  = 2'd3
    } out_kind_t;

    localparam logic [7:0] BASE_A = 8'd0;
    localparam logic [7:0] BASE_C = 8'd1;
    localparam logic [7:0] BASE_G = 8'd2;
    localparam logic [7:0] BASE_T = 8'd3;
    localparam logic [7:0] BASE_N = 8'd4;

    // One queued word: first result, plus a flag for a trailing empty record-complete.
    typedef struct packed {
        out_kind_t          kind;
        logic [7:0]         value;
        logic [LEN_W-1:0]   length;
        logic               two;
    } frp_entry_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic [7:0] base_code(input logic [7:0] b);
        logic [7:0] code;
        case (b)
            8'h41, 8'h61: code = BASE_A;
            8'h43, 8'h63: code = BASE_C;
            8'h47, 8'h67: code = BASE_G;
            8'h54, 8'h74: code = BASE_T;
            default:      code = BASE_N;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/frp_front.sv =====
// Front end: takes input words, tracks the record phase and counters, enqueues results.
`default_nettype none
module frp_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_eos,
    input  wire logic [7:0]         in_byte,
    input  wire logic               q_not_full,
    output logic                    q_push,
    output frp_pkg::frp_entry_t     q_entry
);
    import frp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_NAME = 4'b0010,
        PH_SKIP = 4'b0100,
        PH_SEQ  = 4'b1000
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [NAME_CNT_W-1:0] name_cnt_reg, name_cnt_next;
    logic [LEN_W-1:0]      base_cnt_reg, base_cnt_next;
    logic                  emit;
    logic                  accept;

    assign in_ready = q_not_full;
    assign accept   = in_valid && q_not_full;
    assign q_push   = accept && emit;

    always_comb begin
        phase_next    = phase_reg;
        name_cnt_next = name_cnt_reg;
        base_cnt_next = base_cnt_reg;
        emit          = 1'b0;
        q_entry.kind   = OK_REC_DONE;
        q_entry.value  = '0;
        q_entry.length = '0;
        q_entry.two    = 1'b0;
        if (in_eos == IN_EOS) begin
            unique case (phase_reg)
                PH_NAME: begin
                    emit           = 1'b1;
                    q_entry.kind   = OK_NAME_DONE;
                    q_entry.length = LEN_W'(name_cnt_reg);
                    q_entry.two    = 1'b1;
                end
                PH_SKIP: emit = 1'b1;
                PH_SEQ: begin
                    emit           = 1'b1;
                    q_entry.length = base_cnt_reg;
                end
                PH_IDLE: emit = 1'b0;
                default: emit = 1'b0;
            endcase
            phase_next    = PH_IDLE;
            name_cnt_next = '0;
            base_cnt_next = '0;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (in_byte == CH_HEADER) begin
                        phase_next    = PH_NAME;
                        name_cnt_next = '0;
                        base_cnt_next = '0;
                    end
                end
                PH_NAME: begin
                    emit = 1'b1;
                    if (in_byte == CH_BAR || is_space(in_byte) ||
                        name_cnt_reg >= NAME_CNT_W'(MAX_NAME)) begin
                        q_entry.kind   = OK_NAME_DONE;
                        q_entry.length = LEN_W'(name_cnt_reg);
                        phase_next     = (in_byte == CH_LF) ? PH_SEQ : PH_SKIP;
                    end else begin
                        q_entry.kind  = OK_NAME_BYTE;
                        q_entry.value = in_byte;
                        name_cnt_next = name_cnt_reg + 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (in_byte == CH_LF) begin
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    if (in_byte == CH_HEADER) begin
                        emit           = 1'b1;
                        q_entry.length = base_cnt_reg;
                        phase_next     = PH_NAME;
                        name_cnt_next  = '0;
                        base_cnt_next  = '0;
                    end else if (in_byte != CH_LF) begin
                        emit          = 1'b1;
                        q_entry.kind  = OK_BASE;
                        q_entry.value = base_code(in_byte);
                        // saturate at all ones
                        if (base_cnt_reg != '1) begin
                            base_cnt_next = base_cnt_reg + 1'b1;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            name_cnt_reg <= '0;
            base_cnt_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            name_cnt_reg <= name_cnt_next;
            base_cnt_reg <= base_cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/frp_queue.sv =====
// Short register queue between the front and back ends.
`default_nettype none
module frp_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire frp_pkg::frp_entry_t  push_entry,
    input  wire logic                 pop,
    output frp_pkg::frp_entry_t       head,
    output logic                      not_empty,
    output logic                      not_full
);
    import frp_pkg::*;

    frp_entry_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/frp_back.sv =====
// Back end: expands queued words into results and holds them in the output register.
`default_nettype none
module frp_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire frp_pkg::frp_entry_t  head,
    input  wire logic                 q_not_empty,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output frp_pkg::out_kind_t        out_kind,
    output logic [7:0]                out_value,
    output logic [frp_pkg::LEN_W-1:0] out_length,
    output logic                      out_last
);
    import frp_pkg::*;

    logic             valid_reg;
    logic             second_reg, second_next;
    logic             load;
    out_kind_t        kind_reg, kind_next;
    logic [7:0]       value_reg, value_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic             last_reg, last_next;

    assign load = q_not_empty && (!valid_reg || out_ready);

    always_comb begin
        second_next = second_reg;
        kind_next   = head.kind;
        value_next  = head.value;
        length_next = head.length;
        last_next   = 1'b1;
        q_pop       = 1'b0;
        if (head.two && !second_reg) begin
            // hold the word, emit its trailing empty record next
            last_next   = 1'b0;
            second_next = 1'b1;
        end else if (head.two) begin
            kind_next   = OK_REC_DONE;
            value_next  = '0;
            length_next = '0;
            second_next = 1'b0;
            q_pop       = load;
        end else begin
            q_pop = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            length_reg <= length_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg  <= 1'b1;
                second_reg <= second_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_value  = value_reg;
    assign out_length = length_reg;
    assign out_last   = last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/fasta_record_parser_top.sv =====
// Top level of the FASTA record parser: front end, queue, back end.
// A result passes through a queue slot and then the output register before it appears on m_.
// Throughput: one input word per cycle while the queue has room; an end-of-stream
// word inside a name gives two results and stays at the queue head until both are loaded.
// The queue holds four words, so the input side stalls only when it is full.
// Synchronous active-low reset returns to the before-first-header state, clears
// both counters and empties the queue and output register.
`default_nettype none
module fasta_record_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] value, [39:8] length
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    output logic             m_tlast    // last_of_run
);
    import frp_pkg::*;

    frp_entry_t       push_entry, head;
    logic             q_push, q_pop, q_not_empty, q_not_full;
    out_kind_t        res_kind;
    logic [7:0]       res_value;
    logic [LEN_W-1:0] res_length;

    frp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_eos     (s_tuser[0]),
        .in_byte    (s_tdata),
        .q_not_full (q_not_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    frp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .not_empty  (q_not_empty),
        .not_full   (q_not_full)
    );

    frp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (res_kind),
        .out_value   (res_value),
        .out_length  (res_length),
        .out_last    (m_tlast)
    );

    assign m_tdata = {res_length, res_value};
    assign m_tuser = res_kind;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the FASTA record parser: directed, name-limit, stall and random streams.
`timescale 1ns / 100ps
module tb;
    import frp_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1560;
    localparam int unsigned LONG_HOLD     = 80;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned MAX_PRINTED   = 50;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_NAME = 2'd1,
        PH_SKIP = 2'd2,
        PH_SEQ  = 2'd3
    } parse_phase_t;

    typedef struct packed {
        out_kind_t   kind;
        logic [7:0]  value;
        logic [31:0] length;
        logic        last;
    } result_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
    logic [0:0]  s_tuser  = 1'b0;   // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [7:0] value, [39:8] length
    logic [1:0]  m_tuser;           // [1:0] out_kind
    logic        m_tlast;

    // Parser state as the scoreboard tracks it
    parse_phase_t parse_phase = PH_IDLE;
    logic [6:0]   name_taken  = 7'd0;
    logic [31:0]  bases_seen  = 32'd0;

    result_word_t pending_results[$];
    string        base_letters = "ACGTacgtNn";
    int unsigned  fed_items    = 0;
    int unsigned  mismatches   = 0;
    int unsigned  cycle_count  = 0;
    bit           steady       = 1'b0;
    bit           hold_req     = 1'b0;

    fasta_record_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fasta_record_parser_top regression: fail");
            $finish;
        end
    end

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT)
            || (b == CH_FF) || (b == CH_CR);
    endfunction

    function automatic logic [7:0] nucleotide_code(input logic [7:0] b);
        logic [7:0] code;
        // fold upper case onto lower case; only letters map onto "a".."t" this way
        case (b | 8'h20)
            "a":     code = BASE_A;
            "c":     code = BASE_C;
            "g":     code = BASE_G;
            "t":     code = BASE_T;
            default: code = BASE_N;
        endcase
        return code;
    endfunction

    function automatic result_word_t make_word(input out_kind_t k, input logic [7:0] v,
                                               input logic [31:0] len);
        result_word_t w;
        w.kind   = k;
        w.value  = v;
        w.length = len;
        w.last   = 1'b0;
        return w;
    endfunction

    // Advance the tracked parser by one word, queue its results; return 1 unless ignored
    function automatic bit parse_byte(input logic eos, input logic [7:0] b);
        result_word_t outs[2];
        int           n;
        bit           engaged;
        n = 0;
        engaged = (parse_phase != PH_IDLE);
        if (eos == IN_EOS) begin
            case (parse_phase)
                PH_NAME: begin
                    outs[0] = make_word(OK_NAME_DONE, 8'd0, 32'(name_taken));
                    outs[1] = make_word(OK_REC_DONE, 8'd0, 32'd0);
                    n = 2;
                end
                PH_SKIP: begin
                    outs[0] = make_word(OK_REC_DONE, 8'd0, 32'd0);
                    n = 1;
                end
                PH_SEQ: begin
                    outs[0] = make_word(OK_REC_DONE, 8'd0, bases_seen);
                    n = 1;
                end
                default: ;
            endcase
            parse_phase = PH_IDLE;
            name_taken  = 7'd0;
            bases_seen  = 32'd0;
        end else begin
            case (parse_phase)
                PH_IDLE: begin
                    if (b == CH_HEADER) begin
                        parse_phase = PH_NAME;
                        name_taken  = 7'd0;
                        bases_seen  = 32'd0;
                    end
                end
                PH_NAME: begin
                    if (b == CH_BAR || is_blank(b) || name_taken >= 7'(MAX_NAME)) begin
                        outs[0] = make_word(OK_NAME_DONE, 8'd0, 32'(name_taken));
                        n = 1;
                        parse_phase = (b == CH_LF) ? PH_SEQ : PH_SKIP;
                    end else begin
                        outs[0] = make_word(OK_NAME_BYTE, b, 32'd0);
                        n = 1;
                        name_taken = name_taken + 7'd1;
                    end
                end
                PH_SKIP: begin
                    if (b == CH_LF) parse_phase = PH_SEQ;
                end
                default: begin
                    if (b == CH_HEADER) begin
                        outs[0] = make_word(OK_REC_DONE, 8'd0, bases_seen);
                        n = 1;
                        parse_phase = PH_NAME;
                        name_taken  = 7'd0;
                        bases_seen  = 32'd0;
                    end else if (b != CH_LF) begin
                        outs[0] = make_word(OK_BASE, nucleotide_code(b), 32'd0);
                        n = 1;
                        if (bases_seen != 32'hFFFF_FFFF) bases_seen = bases_seen + 32'd1;
                    end
                end
            endcase
        end
        for (int i = 0; i < n; i++) begin
            outs[i].last = (i == n - 1);
            pending_results.push_back(outs[i]);
        end
        return engaged || (parse_phase != PH_IDLE);
    endfunction

    function automatic logic [7:0] rand_name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_BAR || is_blank(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_line_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] rand_base_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) != 0) return base_letters[$urandom_range(0, 9)];
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_HEADER);
        return b;
    endfunction

    function automatic logic [7:0] pick_terminator();
        logic [7:0] b;
        case ($urandom_range(0, 6))
            0:       b = CH_BAR;
            1:       b = CH_SPACE;
            2:       b = CH_TAB;
            3:       b = CH_LF;
            4:       b = CH_VT;
            5:       b = CH_FF;
            default: b = CH_CR;
        endcase
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic eos, input logic [7:0] b);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= eos;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (parse_byte(eos, b)) fed_items++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_word(IN_DATA, text[i]);
    endtask

    // Hold the input side until every predicted word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        result_word_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word: out_kind %0d value %0d length %0d",
                                          m_tuser, m_tdata[7:0], m_tdata[39:8]));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("out_kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[7:0] !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d (out_kind %0d)",
                                              m_tdata[7:0], want.value, want.kind));
                if (m_tdata[39:8] !== want.length)
                    report_mismatch($sformatf("length %0d, want %0d (out_kind %0d)",
                                              m_tdata[39:8], want.length, want.kind));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, want %b (out_kind %0d)",
                                              m_tlast, want.last, want.kind));
            end
        end
    end

    initial begin : result_receiver
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (hold_req) begin
                stall = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 && !hold_req);
            @(negedge aclk);
        end
    end

    task automatic test_special_cases();
        send_word(IN_EOS, 8'h00);           // end of stream with nothing open
        send_word(IN_EOS, 8'hFF);
        send_word(IN_DATA, 8'hFF);          // junk before the first header
        send_text("A\n>");
        send_word(IN_DATA, 8'hFF);          // high bytes are plain name bytes
        send_word(IN_DATA, 8'h80);
        send_text("|x>\n");                 // '>' in the rest of the header line is skipped
        send_text("AcGt");
        send_word(IN_DATA, 8'hFF);
        send_word(IN_DATA, CH_CR);          // carriage return counts as base N
        send_text("\n>q ");
        send_word(IN_EOS, 8'h00);           // end while skipping the header
        send_text(">z");
        send_word(IN_EOS, 8'h00);           // end inside the name
        send_word(IN_DATA, CH_HEADER);
        send_word(IN_DATA, CH_TAB);         // empty name
        send_word(IN_DATA, CH_LF);
        send_word(IN_EOS, 8'h00);           // empty sequence
        send_text(">\ng");                  // line feed ends the name, sequence starts
        send_word(IN_EOS, 8'h00);
    endtask

    task automatic test_name_limit();
        send_word(IN_DATA, CH_HEADER);
        repeat (MAX_NAME) send_word(IN_DATA, rand_name_byte());
        send_text("x y\nAC");               // 'x' closes the full name and is consumed
        send_word(IN_DATA, CH_HEADER);
        repeat (MAX_NAME) send_word(IN_DATA, rand_name_byte());
        send_text("\nT");                   // line feed at the limit goes straight to sequence
        send_word(IN_EOS, 8'h00);
    endtask

    task automatic test_backpressure();
        steady   = 1'b1;
        hold_req = 1'b1;
        send_text(">r\n");
        repeat (40) send_word(IN_DATA, base_letters[$urandom_range(0, 9)]);
        send_word(IN_EOS, 8'h00);
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_stream();
        int unsigned start;
        int unsigned name_len;
        logic [7:0]  term;
        bit          closed;
        start = fed_items;
        while (fed_items - start < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: any byte, now and then an end of stream
                repeat ($urandom_range(1, 6))
                    send_word(($urandom_range(0, 5) == 0) ? IN_EOS : IN_DATA,
                              8'($urandom_range(0, 255)));
            end else begin
                send_word(IN_DATA, CH_HEADER);
                name_len = ($urandom_range(0, 15) == 0) ? MAX_NAME : $urandom_range(0, 10);
                repeat (name_len) send_word(IN_DATA, rand_name_byte());
                closed = 1'b0;
                if ($urandom_range(0, 19) == 0) begin
                    send_word(IN_EOS, 8'($urandom_range(0, 255)));
                    closed = 1'b1;
                end else begin
                    term = (name_len == MAX_NAME && $urandom_range(0, 1) == 1)
                         ? 8'($urandom_range(0, 255)) : pick_terminator();
                    send_word(IN_DATA, term);
                    if (term != CH_LF) begin
                        repeat ($urandom_range(0, 6)) send_word(IN_DATA, rand_line_byte());
                        if ($urandom_range(0, 11) == 0) begin
                            send_word(IN_EOS, 8'($urandom_range(0, 255)));
                            closed = 1'b1;
                        end else begin
                            send_word(IN_DATA, CH_LF);
                        end
                    end
                end
                if (!closed) begin
                    repeat ($urandom_range(0, 3)) begin
                        repeat ($urandom_range(0, 12)) send_word(IN_DATA, rand_base_byte());
                        send_word(IN_DATA, CH_LF);
                    end
                    if ($urandom_range(0, 4) == 0)
                        send_word(IN_EOS, 8'($urandom_range(0, 255)));
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_special_cases();
        wait_drained();
        test_name_limit();
        wait_drained();
        test_backpressure();
        test_random_stream();
        wait_drained();
        if (mismatches == 0) begin
            $display("fasta_record_parser_top regression: pass");
        end else begin
            $display("fasta_record_parser_top regression: fail");
        end
        $finish;
    end

endmodule
